/* src/fpa_pkg.sv */
// Shared types and constants of the fit-policy partition allocator.
`timescale 1ns / 1ps

package fpa_pkg;

  // Storage geometry.
  localparam int unsigned SLOTS     = 16;
  localparam int unsigned SIZE_BITS = 16;
  localparam int unsigned SLOT_BITS = $clog2(SLOTS);
  localparam int unsigned CNT_BITS  = $clog2(SLOTS + 1);

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SLOT_COUNT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIT_POLICY = 1'b1;

  // Operation codes of an input request.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Fit policies; the unused code behaves as first fit.
  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } policy_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // Input request payload.
  typedef struct packed {
    logic        op;
    logic [3:0]  slot;
    logic [15:0] amount;
    logic        batch_end;
  } in_t;

  // Result payload.
  typedef struct packed {
    logic        granted;
    logic [3:0]  chosen_slot;
    logic [15:0] left_over;
    logic        batch_done;
  } out_t;

  // Configuration seen by the controller.
  typedef struct packed {
    logic [4:0] slot_count;
    logic [1:0] fit_policy;
  } cfg_t;

endpackage

/* src/fpa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module fpa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/fpa_ctrl.sv */
// Request sequencer: loads sizes, scans the size table and writes back the grant.
`timescale 1ns / 1ps

module fpa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fpa_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fpa_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fpa_pkg::out_t out_data_o
);

  import fpa_pkg::*;

  state_e               state_q, state_d;
  logic [CNT_BITS-1:0]  issue_idx_q, count_q, count_d;
  logic                 eval_vld_q;
  logic [SLOT_BITS-1:0] eval_idx_q;
  logic                 found_q;
  logic [SLOT_BITS-1:0] cand_q;
  logic [SIZE_BITS-1:0] best_q;
  logic [SIZE_BITS-1:0] amount_q;
  logic                 bend_q;
  logic                 out_vld_q;
  out_t                 out_q;

  logic                 accept;
  logic                 scan_issue;
  logic                 finish_go;
  logic                 take;
  logic [SIZE_BITS-1:0] left;

  logic                 ram_we;
  logic [SLOT_BITS-1:0] ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [SIZE_BITS-1:0] ram_rdata;

  // Handshake and scan control terms.
  assign accept     = in_valid_i && in_ready_o;
  assign scan_issue = (state_q == ST_SCAN) && (issue_idx_q != count_q);
  assign finish_go  = (state_q == ST_FINISH) && (!out_vld_q || out_ready_i);
  assign left       = best_q - amount_q;

  // Partitions taking part in the scan, saturated to the table depth.
  assign count_d = (cfg_i.slot_count > CNT_BITS'(SLOTS)) ? CNT_BITS'(SLOTS)
                                                         : CNT_BITS'(cfg_i.slot_count);

  // A returned size replaces the candidate when it fits and the policy prefers it.
  assign take = eval_vld_q && (ram_rdata >= amount_q) &&
                (!found_q ||
                 ((cfg_i.fit_policy == POL_BEST)  && (ram_rdata < best_q)) ||
                 ((cfg_i.fit_policy == POL_WORST) && (ram_rdata > best_q)));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_data_i.op == OP_ALLOC)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((issue_idx_q == count_q) && !eval_vld_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the state machine: input ready and the table write port.
  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = in_data_i.slot[SLOT_BITS-1:0];
    ram_wdata  = in_data_i.amount[SIZE_BITS-1:0];
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_we     = in_valid_i && (in_data_i.op == OP_LOAD) &&
                     (CNT_BITS'(in_data_i.slot) < CNT_BITS'(SLOTS));
      end
      ST_FINISH: begin
        ram_we    = finish_go && found_q;
        ram_waddr = cand_q;
        ram_wdata = left;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_idx_q <= '0;
      eval_vld_q  <= 1'b0;
      found_q     <= 1'b0;
      cand_q      <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      eval_vld_q <= scan_issue;
      if (accept && (in_data_i.op == OP_ALLOC)) begin
        issue_idx_q <= '0;
        found_q     <= 1'b0;
        cand_q      <= '0;
      end else begin
        if (scan_issue) begin
          issue_idx_q <= issue_idx_q + CNT_BITS'(1);
        end
        if (take) begin
          found_q <= 1'b1;
          cand_q  <= eval_idx_q;
        end
      end
      if (finish_go) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Request payload, scan pipeline and result register.
  always_ff @(posedge clk_i) begin
    if (accept && (in_data_i.op == OP_ALLOC)) begin
      amount_q <= in_data_i.amount[SIZE_BITS-1:0];
      bend_q   <= in_data_i.batch_end;
      count_q  <= count_d;
    end
    eval_idx_q <= issue_idx_q[SLOT_BITS-1:0];
    if (take) begin
      best_q <= ram_rdata;
    end
    if (finish_go) begin
      out_q.granted     <= found_q;
      out_q.chosen_slot <= found_q ? cand_q : '0;
      out_q.left_over   <= found_q ? left : '0;
      out_q.batch_done  <= bend_q;
    end
  end

  // Remaining-size table.
  fpa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (SLOTS)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (scan_issue),
    .raddr_i (issue_idx_q[SLOT_BITS-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

/* src/fit_policy_partition_allocator.sv */
// Top level of the fit-policy partition allocator: configuration registers and sequencer.
// A load request is taken while the block is idle and writes the size table directly.
// An allocation request scans the first N table entries, where N is slot_count saturated
// to 16; with N zero no entry is read. It writes back its grant once the result register
// is free. The scan reads one table entry per cycle from the size RAM, and a new request
// is accepted once the previous one has written back.
// Reset clears the control state and sets slot_count to 16 and fit_policy to first fit.
`timescale 1ns / 1ps

module fit_policy_partition_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fpa_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [fpa_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  fpa_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output fpa_pkg::out_t                      out_data_o
);

  import fpa_pkg::*;

  cfg_t cfg_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_count <= 5'd16;
      cfg_q.fit_policy <= POL_FIRST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLOT_COUNT: cfg_q.slot_count <= cfg_wdata_i[4:0];
        CFG_FIT_POLICY: cfg_q.fit_policy <= cfg_wdata_i[1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  // Request sequencer with the size table.
  fpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* src/fpa_checker.sv */
// Port-level checker of the fit-policy partition allocator and its bind.
`timescale 1ns / 1ps

module fpa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input fpa_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input fpa_pkg::out_t out_data_o
);

  import fpa_pkg::*;

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // A refused allocation reports neither a partition nor a size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.granted |->
      (out_data_o.chosen_slot == '0) && (out_data_o.left_over == '0))
    else $error("refused allocation carries slot or size");

  // An allocation request occupies the block for its scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.op == OP_ALLOC) |=> !in_ready_o)
    else $error("request taken during a scan");

  // A load request finishes in its own cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.op == OP_LOAD) |=> in_ready_o)
    else $error("load request stalled the input");

endmodule

bind fit_policy_partition_allocator fpa_checker u_fpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* test/tb.sv */
// Self-checking testbench of the fit-policy partition allocator with a scoreboard class.
`timescale 1ns / 1ps

module tb;
  import fpa_pkg::*;

  // Policy code that the block treats as first fit.
  localparam logic [1:0] POL_SPARE = 2'd3;

  // Cycles to let a load request settle before a register write.
  localparam int SETTLE_CYCLES = 40;

  // Bound on the wait for outstanding results.
  localparam int DRAIN_LIMIT = 20000;

  // Random allocation and load requests per configuration phase.
  localparam int PHASE_REQS = 225;

  // Scoreboard: keeps its own copy of the size table and predicts each grant.
  class alloc_scoreboard;
    logic [SIZE_BITS-1:0] free_size [SLOTS];
    logic [4:0]           part_count;
    logic [1:0]           policy_sel;
    out_t                 expected_grants [$];
    int                   errors;

    function new();
      foreach (free_size[k]) free_size[k] = '0;
      part_count = 5'd16;
      policy_sel = POL_FIRST;
      errors     = 0;
    endfunction

    function void set_config(logic [4:0] count, logic [1:0] policy);
      part_count = count;
      policy_sel = policy;
    endfunction

    // Notes an accepted request; an allocation request yields one expected grant.
    function void note_request(in_t req);
      int   span;
      int   pick;
      bit   hit;
      out_t want;
      span = (part_count > SLOTS) ? SLOTS : part_count;
      pick = 0;
      hit  = 1'b0;
      if (req.op == OP_LOAD) begin
        free_size[req.slot] = req.amount;
        return;
      end
      for (int j = 0; j < span; j++) begin
        if (free_size[j] < req.amount) continue;
        if (!hit) begin
          hit  = 1'b1;
          pick = j;
          if (policy_sel != POL_BEST && policy_sel != POL_WORST) break;
        end else if (policy_sel == POL_BEST && free_size[j] < free_size[pick]) begin
          pick = j;
        end else if (policy_sel == POL_WORST && free_size[j] > free_size[pick]) begin
          pick = j;
        end
      end
      want = '0;
      if (hit) begin
        free_size[pick]  = free_size[pick] - req.amount;
        want.granted     = 1'b1;
        want.chosen_slot = 4'(pick);
        want.left_over   = free_size[pick];
      end
      want.batch_done = req.batch_end;
      expected_grants.push_back(want);
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compares one accepted result with the oldest expected grant.
    task check_grant(out_t got);
      out_t want;
      if (expected_grants.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", got));
        return;
      end
      want = expected_grants.pop_front();
      if (got.granted !== want.granted)
        report_mismatch($sformatf("granted %b, expected %b", got.granted, want.granted));
      if (got.chosen_slot !== want.chosen_slot)
        report_mismatch($sformatf("chosen_slot %0d, expected %0d",
                                  got.chosen_slot, want.chosen_slot));
      if (got.left_over !== want.left_over)
        report_mismatch($sformatf("left_over %0d, expected %0d", got.left_over, want.left_over));
      if (got.batch_done !== want.batch_done)
        report_mismatch($sformatf("batch_done %b, expected %b",
                                  got.batch_done, want.batch_done));
    endtask
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  in_t                      in_data_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  out_t                     out_data_o;

  alloc_scoreboard sb;
  bit              calm = 1'b0;

  // Initial partition sizes: extremes, equal sizes and a few odd values.
  logic [15:0] seed_sizes [16] = '{16'd100, 16'd0, 16'hFFFF, 16'd300, 16'd300, 16'd5000,
                                   16'd300, 16'd40000, 16'd7, 16'd12345, 16'd300,
                                   16'd65534, 16'd1, 16'd2048, 16'd999, 16'd30000};

  // Settings walked through after the directed requests.
  logic [4:0] phase_count  [8] = '{5'd16, 5'd16, 5'd0, 5'd31, 5'd1, 5'd9, 5'd17, 5'd5};
  logic [1:0] phase_policy [8] = '{POL_BEST, POL_WORST, POL_FIRST, POL_SPARE,
                                   POL_BEST, POL_WORST, POL_FIRST, POL_SPARE};

  fit_policy_partition_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Offers one request, with an optional random gap first, and waits for acceptance.
  task automatic send_req(input logic op, input logic [3:0] slot, input logic [15:0] amount,
                          input logic batch_end);
    in_t req;
    req.op        = op;
    req.slot      = slot;
    req.amount    = amount;
    req.batch_end = batch_end;
    if (!calm) begin
      while ($urandom_range(99) < 16) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(req);
  endtask

  // Stops offering requests and waits until every expected grant has come back.
  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (sb.expected_grants.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes both registers on consecutive cycles while the block is idle.
  task automatic apply_config(input logic [4:0] count, input logic [1:0] policy);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SLOT_COUNT;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_FIT_POLICY;
    cfg_wdata_i <= CFG_DATA_BITS'(policy);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_config(count, policy);
  endtask

  // Result side: random stalls, plus long hold-offs that back the block up.
  initial begin : result_sink
    int hold_left;
    int seen;
    hold_left = 0;
    seen      = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_grant(out_data_o);
        seen++;
        if (seen == 40 || seen == 1000) hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  // Request side: directed requests, then random phases under several settings.
  initial begin : stimulus
    logic        op_sel;
    logic [3:0]  slot_sel;
    logic [15:0] amt;
    logic [15:0] base;
    logic        be;
    int          roll;
    sb = new();
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load every partition under the reset settings; one load carries a batch end.
    for (int j = 0; j < 16; j++) send_req(OP_LOAD, 4'(j), seed_sizes[j], j == 7);

    // First fit: zero request, full-size request, refusal, exact fit, skip, batch end.
    send_req(OP_ALLOC, 4'd15, 16'd0, 1'b0);
    send_req(OP_ALLOC, 4'd0, 16'hFFFF, 1'b0);
    send_req(OP_ALLOC, 4'd9, 16'hFFFF, 1'b1);
    send_req(OP_ALLOC, 4'd3, 16'd300, 1'b1);
    send_req(OP_ALLOC, 4'd6, 16'd301, 1'b0);
    send_req(OP_ALLOC, 4'd12, 16'd100, 1'b0);

    for (int phase = 0; phase < 8; phase++) begin
      drain_results();
      apply_config(phase_count[phase], phase_policy[phase]);
      calm = (phase == 5);
      for (int n = 0; n < PHASE_REQS; n++) begin
        op_sel   = ($urandom_range(99) < 30) ? OP_LOAD : OP_ALLOC;
        slot_sel = 4'($urandom_range(15));
        be       = ($urandom_range(3) == 0);
        roll     = $urandom_range(9);
        if (op_sel == OP_LOAD) begin
          if (roll < 5) amt = 16'($urandom_range(65535));
          else if (roll < 8) amt = 16'($urandom_range(2000));
          else amt = (roll == 8) ? 16'd0 : 16'hFFFF;
        end else begin
          // Mostly aim near a current partition size so both fits and misses occur.
          base = sb.free_size[$urandom_range(SLOTS - 1)];
          if (roll < 4) amt = base + 16'($urandom_range(2)) - 16'd1;
          else if (roll < 7) amt = 16'($urandom_range(1000));
          else if (roll < 9) amt = 16'($urandom_range(65535));
          else amt = ($urandom_range(1) == 0) ? 16'd0 : 16'hFFFF;
        end
        send_req(op_sel, slot_sel, amt, be);
      end
    end

    drain_results();
    if (sb.expected_grants.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_grants.size()));
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* filelist.f */
src/fpa_pkg.sv
src/fpa_ram.sv
src/fpa_ctrl.sv
src/fit_policy_partition_allocator.sv
src/fpa_checker.sv
test/tb.sv
